// ----- sv/fmpr_pkg.sv -----
package fmpr_pkg;

  localparam int unsigned WINDOW_DEPTH = 8;
  localparam int unsigned RING_AW      = $clog2(WINDOW_DEPTH);

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned PPL_W     = 24;
  localparam int unsigned MINP_W    = 20;
  localparam int unsigned MINR_W    = 16;
  localparam int unsigned CFG_W     = 24;
  localparam int unsigned VSCALE_W  = 18;
  localparam int unsigned FSCALE_W  = 28;
  localparam int unsigned NUM_W     = 64;
  localparam int unsigned DEN_W     = PPL_W + WORD_W;
  localparam int unsigned QUO_W     = 32;
  localparam int unsigned DIV_STEPS = QUO_W;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  localparam logic [VSCALE_W-1:0] VOL_SCALE  = VSCALE_W'(256000);
  localparam logic [FSCALE_W-1:0] FLOW_SCALE = FSCALE_W'(256000000);

  localparam logic [PPL_W-1:0]  PPL_RESET  = PPL_W'(256);
  localparam logic [MINP_W-1:0] MINP_RESET = MINP_W'(10000);
  localparam logic [MINR_W-1:0] MINR_RESET = MINR_W'(100);

  localparam logic [1:0] FUNC_EDGE  = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  localparam logic [1:0] CFG_PPL  = 2'd0;
  localparam logic [1:0] CFG_MINP = 2'd1;
  localparam logic [1:0] CFG_MINR = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_VMUL,
    ST_VDIV,
    ST_VWAIT,
    ST_DIFF,
    ST_FMUL,
    ST_FDIV,
    ST_FWAIT,
    ST_DONE
  } fsm_e;

  typedef enum logic {
    DIV_IDLE,
    DIV_RUN
  } div_state_e;

  typedef struct packed {
    logic [WORD_W-1:0] count;
    logic [WORD_W-1:0] stamp;
  } ring_entry_t;

  typedef struct packed {
    logic               we;
    logic [RING_AW-1:0] waddr;
    ring_entry_t        wdata;
    logic               re;
    logic [RING_AW-1:0] raddr;
  } ring_req_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;

endpackage

// ----- sv/flow_meter_pulse_rate.sv -----
// channel   | dir | tdata                          | tuser
// s_axis    | in  | time_stamp[31:0]               | func[1:0]
// m_axis    | out | volume_ml, flow_ml_per_s,      | volume_only, rate_undefined
//           |     | pulse_total, ignored_total     |
// cfg       | in  | cfg_wdata_i to register cfg_idx_i when cfg_we_i is high
//
// One word at a time. An edge or unused code passes through ST_DONE to the output register;
// a read runs the 32-step radix-2 divider once for the volume and, for a full read with a
// nonzero window, once more for the flow.
// Reset clears all counters, held values and the ring valid bits at once.
// s_axis_tready is low while a word is in work; a finished result waits in the output
// register and the next word is taken meanwhile.
module flow_meter_pulse_rate (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,   // time_stamp[31:0]
  input  logic [1:0]   s_axis_tuser,   // func[1:0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,   // volume_ml, flow_ml_per_s, pulse_total, ignored_total
  output logic [1:0]   m_axis_tuser,   // volume_only, rate_undefined
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [23:0]  cfg_wdata_i
);

  localparam int unsigned W = fmpr_pkg::WORD_W;

  fmpr_pkg::fsm_e                    state_q, state_d;
  logic [fmpr_pkg::PPL_W-1:0]        ppl_q;
  logic [fmpr_pkg::MINP_W-1:0]       minp_q;
  logic [fmpr_pkg::MINR_W-1:0]       minr_q;
  logic [W-1:0]                      now_q, now_d;
  logic [W-1:0]                      acc_q, acc_d;
  logic [W-1:0]                      rej_q, rej_d;
  logic [W-1:0]                      ledge_q, ledge_d;
  logic [W-1:0]                      lread_q, lread_d;
  logic [fmpr_pkg::RING_AW-1:0]      slot_q, slot_d;
  logic [fmpr_pkg::RING_AW-1:0]      old_addr;
  logic [W-1:0]                      hvol_q, hvol_d;
  logic [W-1:0]                      hflow_q, hflow_d;
  logic                              vonly_q, vonly_d;
  logic                              undef_q, undef_d;
  logic [W-1:0]                      dcnt_q, dcnt_d;
  logic [W-1:0]                      dms_q, dms_d;
  logic [fmpr_pkg::NUM_W-1:0]        num_q, num_d;
  logic [fmpr_pkg::DEN_W-1:0]        den_q, den_d;
  logic                              mvalid_q, mvalid_d;
  logic [127:0]                      mdata_q, mdata_d;
  logic [1:0]                        muser_q, muser_d;
  logic [W+fmpr_pkg::VSCALE_W-1:0]   vprod;
  logic [W+fmpr_pkg::FSCALE_W-1:0]   fprod;
  logic [fmpr_pkg::DEN_W-1:0]        dprod;
  logic [W-1:0]                      dms_new;
  logic                              accept;
  fmpr_pkg::ring_req_t               ring_req;
  fmpr_pkg::ring_entry_t             ring_rd;
  fmpr_pkg::div_req_t                div_req;
  fmpr_pkg::div_rsp_t                div_rsp;

  fmpr_ring u_ring (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ring_req),
    .rd_o   (ring_rd)
  );

  fmpr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign s_axis_tready = (state_q == fmpr_pkg::ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign old_addr      = (slot_q == fmpr_pkg::RING_AW'(fmpr_pkg::WINDOW_DEPTH - 1)) ?
                         '0 : slot_q + fmpr_pkg::RING_AW'(1);
  assign vprod         = acc_q * fmpr_pkg::VOL_SCALE;
  assign fprod         = dcnt_q * fmpr_pkg::FLOW_SCALE;
  assign dprod         = ppl_q * dms_q;
  assign dms_new       = now_q - ring_rd.stamp;

  always_comb begin
    state_d  = state_q;
    now_d    = now_q;
    acc_d    = acc_q;
    rej_d    = rej_q;
    ledge_d  = ledge_q;
    lread_d  = lread_q;
    slot_d   = slot_q;
    hvol_d   = hvol_q;
    hflow_d  = hflow_q;
    vonly_d  = vonly_q;
    undef_d  = undef_q;
    dcnt_d   = dcnt_q;
    dms_d    = dms_q;
    num_d    = num_q;
    den_d    = den_q;
    mvalid_d = mvalid_q && !m_axis_tready;
    mdata_d  = mdata_q;
    muser_d  = muser_q;
    ring_req = '0;
    div_req  = '0;
    unique case (state_q)
      fmpr_pkg::ST_IDLE: begin
        if (accept) begin
          now_d   = s_axis_tdata;
          vonly_d = 1'b0;
          undef_d = 1'b0;
          state_d = fmpr_pkg::ST_DONE;
          case (s_axis_tuser)
            fmpr_pkg::FUNC_EDGE: begin
              if ((s_axis_tdata - ledge_q) > W'(minp_q)) begin
                acc_d = acc_q + W'(1);
              end else begin
                rej_d = rej_q + W'(1);
              end
              ledge_d = s_axis_tdata;
            end
            fmpr_pkg::FUNC_READ: begin
              state_d = fmpr_pkg::ST_VMUL;
            end
            fmpr_pkg::FUNC_CLEAR: begin
              acc_d   = '0;
              state_d = fmpr_pkg::ST_VMUL;
            end
            default: state_d = fmpr_pkg::ST_DONE;
          endcase
        end
      end
      fmpr_pkg::ST_VMUL: begin
        num_d   = fmpr_pkg::NUM_W'(vprod);
        den_d   = fmpr_pkg::DEN_W'(ppl_q);
        state_d = fmpr_pkg::ST_VDIV;
      end
      fmpr_pkg::ST_VDIV: begin
        div_req = '{start: 1'b1, num: num_q, den: den_q};
        state_d = fmpr_pkg::ST_VWAIT;
      end
      fmpr_pkg::ST_VWAIT: begin
        if (div_rsp.done) begin
          hvol_d = div_rsp.quo;
          if ((now_q - lread_q) < W'(minr_q)) begin
            vonly_d = 1'b1;
            state_d = fmpr_pkg::ST_DONE;
          end else begin
            ring_req = '{we: 1'b1, waddr: slot_q, wdata: '{count: acc_q, stamp: now_q},
                         re: 1'b1, raddr: old_addr};
            state_d  = fmpr_pkg::ST_DIFF;
          end
        end
      end
      fmpr_pkg::ST_DIFF: begin
        dcnt_d  = acc_q - ring_rd.count;
        dms_d   = dms_new;
        slot_d  = old_addr;
        lread_d = now_q;
        if (dms_new == '0) begin
          hflow_d = '0;
          undef_d = 1'b1;
          state_d = fmpr_pkg::ST_DONE;
        end else begin
          state_d = fmpr_pkg::ST_FMUL;
        end
      end
      fmpr_pkg::ST_FMUL: begin
        num_d   = fmpr_pkg::NUM_W'(fprod);
        den_d   = dprod;
        state_d = fmpr_pkg::ST_FDIV;
      end
      fmpr_pkg::ST_FDIV: begin
        div_req = '{start: 1'b1, num: num_q, den: den_q};
        state_d = fmpr_pkg::ST_FWAIT;
      end
      fmpr_pkg::ST_FWAIT: begin
        if (div_rsp.done) begin
          hflow_d = div_rsp.quo;
          state_d = fmpr_pkg::ST_DONE;
        end
      end
      fmpr_pkg::ST_DONE: begin
        if (!mvalid_q || m_axis_tready) begin
          mvalid_d = 1'b1;
          mdata_d  = {rej_q, acc_q, hflow_q, hvol_q};
          muser_d  = {undef_q, vonly_q};
          state_d  = fmpr_pkg::ST_IDLE;
        end
      end
      default: state_d = fmpr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= fmpr_pkg::ST_IDLE;
      ppl_q    <= fmpr_pkg::PPL_RESET;
      minp_q   <= fmpr_pkg::MINP_RESET;
      minr_q   <= fmpr_pkg::MINR_RESET;
      acc_q    <= '0;
      rej_q    <= '0;
      ledge_q  <= '0;
      lread_q  <= '0;
      slot_q   <= '0;
      hvol_q   <= '0;
      hflow_q  <= '0;
      vonly_q  <= 1'b0;
      undef_q  <= 1'b0;
      mvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      acc_q    <= acc_d;
      rej_q    <= rej_d;
      ledge_q  <= ledge_d;
      lread_q  <= lread_d;
      slot_q   <= slot_d;
      hvol_q   <= hvol_d;
      hflow_q  <= hflow_d;
      vonly_q  <= vonly_d;
      undef_q  <= undef_d;
      mvalid_q <= mvalid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          fmpr_pkg::CFG_PPL:  ppl_q  <= cfg_wdata_i[fmpr_pkg::PPL_W-1:0];
          fmpr_pkg::CFG_MINP: minp_q <= cfg_wdata_i[fmpr_pkg::MINP_W-1:0];
          fmpr_pkg::CFG_MINR: minr_q <= cfg_wdata_i[fmpr_pkg::MINR_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    now_q   <= now_d;
    dcnt_q  <= dcnt_d;
    dms_q   <= dms_d;
    num_q   <= num_d;
    den_q   <= den_d;
    mdata_q <= mdata_d;
    muser_q <= muser_d;
  end

  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tdata  = mdata_q;
  assign m_axis_tuser  = muser_q;

endmodule

// ----- sv/fmpr_ring.sv -----
module fmpr_ring (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  fmpr_pkg::ring_req_t   req_i,
  output fmpr_pkg::ring_entry_t rd_o
);

  fmpr_pkg::ring_entry_t                    mem [fmpr_pkg::WINDOW_DEPTH];
  logic [fmpr_pkg::WINDOW_DEPTH-1:0]        valid_q;
  fmpr_pkg::ring_entry_t                    rd_q;
  logic                                     rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_q <= mem[req_i.raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        valid_q[req_i.waddr] <= 1'b1;
      end
      if (req_i.re) begin
        rd_vld_q <= valid_q[req_i.raddr];
      end
    end
  end

  assign rd_o = rd_vld_q ? rd_q : '0;

endmodule

// ----- sv/fmpr_div.sv -----
module fmpr_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fmpr_pkg::div_req_t req_i,
  output fmpr_pkg::div_rsp_t rsp_o
);

  fmpr_pkg::div_state_e                state_q, state_d;
  logic [fmpr_pkg::DEN_W:0]            rem_q, rem_d;
  logic [fmpr_pkg::DEN_W-1:0]          den_q, den_d;
  logic [fmpr_pkg::QUO_W-1:0]          sh_q, sh_d;
  logic [fmpr_pkg::QUO_W-1:0]          quo_q, quo_d;
  logic [fmpr_pkg::CNT_W-1:0]          cnt_q, cnt_d;
  logic                                done_q, done_d;
  logic [fmpr_pkg::DEN_W:0]            trial;
  logic                                fits;
  logic [fmpr_pkg::DEN_W-1:0]          num_hi;

  assign trial  = {rem_q[fmpr_pkg::DEN_W-1:0], sh_q[fmpr_pkg::QUO_W-1]};
  assign fits   = trial >= {1'b0, den_q};
  assign num_hi = fmpr_pkg::DEN_W'(req_i.num[fmpr_pkg::NUM_W-1:fmpr_pkg::QUO_W]);

  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    den_d   = den_q;
    sh_d    = sh_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    unique case (state_q)
      fmpr_pkg::DIV_IDLE: begin
        if (req_i.start) begin
          den_d = req_i.den;
          if (req_i.den == '0 || num_hi >= req_i.den) begin
            quo_d  = '1;
            done_d = 1'b1;
          end else begin
            rem_d   = {1'b0, num_hi};
            sh_d    = req_i.num[fmpr_pkg::QUO_W-1:0];
            cnt_d   = '0;
            state_d = fmpr_pkg::DIV_RUN;
          end
        end
      end
      fmpr_pkg::DIV_RUN: begin
        rem_d = fits ? trial - {1'b0, den_q} : trial;
        sh_d  = {sh_q[fmpr_pkg::QUO_W-2:0], fits};
        cnt_d = cnt_q + fmpr_pkg::CNT_W'(1);
        if (cnt_q == fmpr_pkg::CNT_W'(fmpr_pkg::DIV_STEPS - 1)) begin
          quo_d   = {sh_q[fmpr_pkg::QUO_W-2:0], fits};
          done_d  = 1'b1;
          state_d = fmpr_pkg::DIV_IDLE;
        end
      end
      default: state_d = fmpr_pkg::DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fmpr_pkg::DIV_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    sh_q  <= sh_d;
    quo_q <= quo_d;
  end

  assign rsp_o = '{done: done_q, quo: quo_q};

endmodule

// ----- sv/fmpr_chk.sv -----
module fmpr_chk (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [127:0] m_axis_tdata,
  input logic [1:0]   m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                        && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("word taken while another is in work");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("volume_only and rate_undefined both set");

  a_undef_zero_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata[63:32] == '0)
    else $error("undefined rate with nonzero flow");

endmodule

bind flow_meter_pulse_rate fmpr_chk u_fmpr_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
